// File: sv/pcfd_pkg.sv
// Shared constants, types and helper functions for the PDM CIC/FIR decimator.
// No dependencies; used by every module of the block.
`default_nettype none

package pcfd_pkg;

   localparam int TAPS       = 64;
   localparam int WORD_BITS  = 32;
   localparam int TAP_W      = $clog2(TAPS);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int SMP_W      = 16;
   localparam int INT_W      = 32;
   localparam int WRAP_W     = 35;
   localparam int ACC_W      = 2 * SMP_W + TAP_W;
   localparam int SHIFT_W    = 5;
   localparam int QDEPTH     = 4;
   localparam int QP_W       = $clog2(QDEPTH);
   localparam int QC_W       = $clog2(QDEPTH + 1);
   localparam int COEF_COUNT = 64;
   localparam int COEF_W     = $clog2(COEF_COUNT);
   localparam int HALF_BIT   = WORD_BITS / 2;

   localparam logic signed [WRAP_W-1:0] WRAP_HI = 35'sd1073741823;
   localparam logic signed [WRAP_W-1:0] WRAP_LO = -35'sd1073741824;

   localparam logic signed [SMP_W-1:0] COEF_ROM [COEF_COUNT] = '{
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd2, 16'sd0, -16'sd9,
      16'sd8, 16'sd24, -16'sd43, -16'sd38, 16'sd144, -16'sd1, -16'sd343, 16'sd224,
      16'sd603, -16'sd838, -16'sd725, 16'sd2128, 16'sd234, -16'sd4795, 16'sd2229, 16'sd17687,
      16'sd17687, 16'sd2229, -16'sd4795, 16'sd234, 16'sd2128, -16'sd725, -16'sd838, 16'sd603,
      16'sd224, -16'sd343, -16'sd1, 16'sd144, -16'sd38, -16'sd43, 16'sd24, 16'sd8,
      -16'sd9, 16'sd0, 16'sd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0
   };

   typedef struct packed {
      logic signed [SMP_W-1:0] sample;
      logic                    last;
   } q_item_type;

   typedef struct packed {
      logic room2;
      logic not_empty;
   } q_stat_type;

   typedef enum logic {
      FE_IDLE,
      FE_RUN
   } fe_state_type;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_LOAD,
      BE_MAC,
      BE_DRAIN,
      BE_DONE
   } be_state_type;

   // high side folds first, then the low side on the folded value
   function automatic logic signed [WRAP_W-1:0] wrap_value(input logic signed [WRAP_W-1:0] v);
      logic signed [WRAP_W-1:0] t;
      t = v;
      if (t >= WRAP_HI) t = t - WRAP_HI;
      if (t <= WRAP_LO) t = t - WRAP_LO;
      return t;
   endfunction

   // taps past the table take zero
   function automatic logic signed [SMP_W-1:0] coef_at(input logic [TAP_W-1:0] a);
      logic [31:0] ai;
      logic signed [SMP_W-1:0] c;
      ai = 32'(a);
      c  = '0;
      if (ai < COEF_COUNT) c = COEF_ROM[ai[COEF_W-1:0]];
      return c;
   endfunction

endpackage

`default_nettype wire

// File: sv/pdm_cic_fir_decimator_top.sv
// Top level of the PDM to PCM decimator: front end, sample queue, FIR back end
// and the out_shift register. Uses pcfd_pkg, pcfd_front, pcfd_queue, pcfd_back.
`default_nettype none

// Each 32-bit PDM word (MSB first, 1 = +1, 0 = -1) runs through a second-order
// CIC one bit per cycle and yields two 16-bit samples, which a 4-entry queue
// hands to a 64-tap FIR built around one 16x16 multiplier. Each sample passes
// the back end in order (pop, history write, 64 multiply-accumulates, pipeline
// drain, result load), so the shared multiplier sets the sustained word rate.
// The front end takes a new word once it is done with the last one and the
// queue has room for two samples. Two results leave per word, rsp_tlast marking
// the second. out_shift arithmetically shifts the FIR sum right before its low
// 16 bits go out; write it only while idle.
module pdm_cic_fir_decimator_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire [pcfd_pkg::WORD_BITS-1:0]      req_tdata,   // [31:0] pdm_word
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic signed [pcfd_pkg::SMP_W-1:0]  rsp_tdata,   // [15:0] pcm_value
   output logic                               rsp_tlast,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire [pcfd_pkg::SHIFT_W-1:0]        csr_wdata    // [4:0] out_shift
);

   logic [pcfd_pkg::SHIFT_W-1:0] out_shift_ff;

   pcfd_pkg::q_stat_type q_stat;
   pcfd_pkg::q_item_type push_item;
   pcfd_pkg::q_item_type head_item;
   logic                 push;
   logic                 pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) out_shift_ff <= '0;
      else if (csr_valid && csr_ready) out_shift_ff <= csr_wdata;
   end

   pcfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .push       (push),
      .push_item  (push_item)
   );

   pcfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   pcfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .q_stat     (q_stat),
      .pop        (pop),
      .out_shift  (out_shift_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: sv/pcfd_front.sv
// Front end: takes PDM words, runs the two integrators one bit per cycle and
// the two comb stages per sample, and pushes 16-bit samples. Uses pcfd_pkg.
`default_nettype none

module pcfd_front (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire [pcfd_pkg::WORD_BITS-1:0]  req_tdata,   // [31:0] pdm_word
   input  pcfd_pkg::q_stat_type           q_stat,
   output logic                           push,
   output pcfd_pkg::q_item_type           push_item
);

   pcfd_pkg::fe_state_type state_ff, state_in;

   logic [pcfd_pkg::WORD_BITS-1:0]      word_ff;
   logic [pcfd_pkg::BIT_W-1:0]          cnt_ff;
   logic signed [pcfd_pkg::INT_W-1:0]   int1_ff, int1_in;
   logic signed [pcfd_pkg::INT_W-1:0]   int2_ff, int2_in;
   logic signed [pcfd_pkg::INT_W-1:0]   smp_ff;
   logic                                smp_pend_ff;
   logic                                smp_last_ff;
   logic signed [pcfd_pkg::INT_W-1:0]   cdf_ff;
   logic signed [pcfd_pkg::INT_W:0]     cds_ff;

   logic                                accept;
   logic                                running;
   logic signed [pcfd_pkg::WRAP_W-1:0]  step;
   logic signed [pcfd_pkg::INT_W:0]     d1;
   logic signed [pcfd_pkg::WRAP_W-1:0]  p_wr;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcfd_pkg::FE_IDLE: if (accept) state_in = pcfd_pkg::FE_RUN;
         pcfd_pkg::FE_RUN:
            if (cnt_ff == pcfd_pkg::BIT_W'(pcfd_pkg::WORD_BITS - 1))
               state_in = pcfd_pkg::FE_IDLE;
         default: state_in = pcfd_pkg::FE_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      running    = 1'b0;
      unique case (state_ff)
         pcfd_pkg::FE_IDLE: req_tready = q_stat.room2;
         pcfd_pkg::FE_RUN:  running    = 1'b1;
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // integrators, MSB of the word first
   always_comb begin
      step    = word_ff[pcfd_pkg::WORD_BITS-1] ? 35'sd1 : -35'sd1;
      int1_in = pcfd_pkg::INT_W'(pcfd_pkg::wrap_value(pcfd_pkg::WRAP_W'(int1_ff) + step));
      int2_in = pcfd_pkg::INT_W'(pcfd_pkg::wrap_value(
                   pcfd_pkg::WRAP_W'(int2_ff) + pcfd_pkg::WRAP_W'(int1_in)));
   end

   // comb stages on the captured sample
   always_comb begin
      d1   = (pcfd_pkg::INT_W+1)'(smp_ff) - (pcfd_pkg::INT_W+1)'(cdf_ff);
      p_wr = pcfd_pkg::wrap_value(pcfd_pkg::WRAP_W'(d1) - pcfd_pkg::WRAP_W'(cds_ff));
   end

   assign push             = smp_pend_ff;
   assign push_item.sample = p_wr[pcfd_pkg::SMP_W-1:0];
   assign push_item.last   = smp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pcfd_pkg::FE_IDLE;
         cnt_ff      <= '0;
         int1_ff     <= '0;
         int2_ff     <= '0;
         smp_pend_ff <= 1'b0;
         smp_last_ff <= 1'b0;
         cdf_ff      <= '0;
         cds_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         smp_pend_ff <= 1'b0;
         if (accept) begin
            cnt_ff <= '0;
         end else if (running) begin
            int1_ff <= int1_in;
            int2_ff <= int2_in;
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == '0) begin
               smp_pend_ff <= 1'b1;
               smp_last_ff <= 1'b0;
            end else if (cnt_ff == pcfd_pkg::BIT_W'(pcfd_pkg::HALF_BIT)) begin
               smp_pend_ff <= 1'b1;
               smp_last_ff <= 1'b1;
            end
         end
         if (smp_pend_ff) begin
            cdf_ff <= smp_ff;
            cds_ff <= d1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) word_ff <= req_tdata;
      else if (running) word_ff <= {word_ff[pcfd_pkg::WORD_BITS-2:0], 1'b0};
      if (running) smp_ff <= int2_in;
   end

endmodule

`default_nettype wire

// File: sv/pcfd_queue.sv
// Short sample queue between front and back end. Reports empty status and
// whether two more samples fit. Uses pcfd_pkg.
`default_nettype none

module pcfd_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  pcfd_pkg::q_item_type    push_item,
   input  wire                     pop,
   output pcfd_pkg::q_item_type    head_item,
   output pcfd_pkg::q_stat_type    q_stat
);

   pcfd_pkg::q_item_type            slot_ff [pcfd_pkg::QDEPTH];
   logic [pcfd_pkg::QP_W-1:0]       wr_ptr_ff;
   logic [pcfd_pkg::QP_W-1:0]       rd_ptr_ff;
   logic [pcfd_pkg::QC_W-1:0]       count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   assign head_item        = slot_ff[rd_ptr_ff];
   assign q_stat.not_empty = (count_ff != '0);
   assign q_stat.room2     = (count_ff <= pcfd_pkg::QC_W'(pcfd_pkg::QDEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

`default_nettype wire

// File: sv/pcfd_back.sv
// Back end: FIR with tap history memory and one shared multiply-accumulate,
// plus the result register. Uses pcfd_pkg.
`default_nettype none

module pcfd_back (
   input  wire                                 clock,
   input  wire                                 reset,
   input  pcfd_pkg::q_item_type                head_item,
   input  pcfd_pkg::q_stat_type                q_stat,
   output logic                                pop,
   input  wire [pcfd_pkg::SHIFT_W-1:0]         out_shift,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic signed [pcfd_pkg::SMP_W-1:0]   rsp_tdata,
   output logic                                rsp_tlast
);

   pcfd_pkg::be_state_type state_ff, state_in;

   logic signed [pcfd_pkg::SMP_W-1:0]    hist_mem [pcfd_pkg::TAPS];
   logic [pcfd_pkg::TAPS-1:0]            hist_ok_ff;

   logic signed [pcfd_pkg::SMP_W-1:0]    cur_ff;
   logic                                 cur_last_ff;
   logic [pcfd_pkg::TAP_W-1:0]           pos_ff;
   logic [pcfd_pkg::TAP_W-1:0]           rd_addr_ff;
   logic [pcfd_pkg::TAP_W-1:0]           tap_ff;

   logic signed [pcfd_pkg::SMP_W-1:0]    rd_data_ff;
   logic                                 rd_ok_ff;
   logic signed [pcfd_pkg::SMP_W-1:0]    coef1_ff;
   logic                                 v1_ff;
   logic signed [2*pcfd_pkg::SMP_W-1:0]  prod_ff;
   logic                                 v2_ff;
   logic signed [pcfd_pkg::ACC_W-1:0]    acc_ff;
   logic                                 rsp_tvalid_ff;
   logic signed [pcfd_pkg::SMP_W-1:0]    rsp_data_ff;
   logic                                 rsp_last_ff;

   logic                                 wr_en;
   logic                                 rd_en;
   logic                                 load_out;
   logic                                 out_free;
   logic                                 last_tap;
   logic signed [pcfd_pkg::SMP_W-1:0]    mul_a;
   logic signed [pcfd_pkg::ACC_W-1:0]    shifted;

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign last_tap = (tap_ff == pcfd_pkg::TAP_W'(pcfd_pkg::TAPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcfd_pkg::BE_IDLE:  if (q_stat.not_empty) state_in = pcfd_pkg::BE_LOAD;
         pcfd_pkg::BE_LOAD:  state_in = pcfd_pkg::BE_MAC;
         pcfd_pkg::BE_MAC:   if (last_tap) state_in = pcfd_pkg::BE_DRAIN;
         pcfd_pkg::BE_DRAIN: if (!v1_ff && !v2_ff) state_in = pcfd_pkg::BE_DONE;
         pcfd_pkg::BE_DONE:  if (out_free) state_in = pcfd_pkg::BE_IDLE;
         default:            state_in = pcfd_pkg::BE_IDLE;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         pcfd_pkg::BE_IDLE: pop      = q_stat.not_empty;
         pcfd_pkg::BE_LOAD: wr_en    = 1'b1;
         pcfd_pkg::BE_MAC:  rd_en    = 1'b1;
         pcfd_pkg::BE_DONE: load_out = out_free;
         default: ;
      endcase
   end

   assign mul_a   = rd_ok_ff ? rd_data_ff : '0;
   assign shifted = acc_ff >>> out_shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pcfd_pkg::BE_IDLE;
         hist_ok_ff    <= '0;
         pos_ff        <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= rd_en;
         v2_ff    <= v1_ff;
         if (wr_en) hist_ok_ff[pos_ff] <= 1'b1;
         if (load_out) begin
            rsp_tvalid_ff <= 1'b1;
            pos_ff <= (pos_ff == pcfd_pkg::TAP_W'(pcfd_pkg::TAPS - 1)) ? '0 : pos_ff + 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // history memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) hist_mem[pos_ff] <= cur_ff;
      if (rd_en) rd_data_ff <= hist_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff      <= head_item.sample;
         cur_last_ff <= head_item.last;
      end
      if (wr_en) begin
         rd_addr_ff <= pos_ff;
         tap_ff     <= '0;
         acc_ff     <= '0;
      end
      if (rd_en) begin
         rd_ok_ff <= hist_ok_ff[rd_addr_ff];
         coef1_ff <= pcfd_pkg::coef_at(tap_ff);
         tap_ff   <= tap_ff + 1'b1;
         // walk backward through the ring, newest first
         rd_addr_ff <= (rd_addr_ff == '0) ? pcfd_pkg::TAP_W'(pcfd_pkg::TAPS - 1)
                                          : rd_addr_ff - 1'b1;
      end
      if (v1_ff) prod_ff <= mul_a * coef1_ff;
      if (v2_ff) acc_ff <= acc_ff + pcfd_pkg::ACC_W'(prod_ff);
      if (load_out) begin
         rsp_data_ff <= shifted[pcfd_pkg::SMP_W-1:0];
         rsp_last_ff <= cur_last_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// File: sv/pcfd_checker.sv
// Port-level checks for the decimator top, attached by bind below.
// Depends on pcfd_pkg and pdm_cic_fir_decimator_top.
`default_nettype none

module pcfd_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_tvalid,
   input wire                        req_tready,
   input wire                        rsp_tvalid,
   input wire                        rsp_tready,
   input wire [pcfd_pkg::SMP_W-1:0]  rsp_tdata,
   input wire                        rsp_tlast
);

   logic       exp_last_ff;
   logic [7:0] owed_ff;

   // results still owed: two per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_last_ff <= 1'b0;
         owed_ff     <= '0;
      end else begin
         if (rsp_tvalid && rsp_tready) exp_last_ff <= !exp_last_ff;
         owed_ff <= owed_ff + ((req_tvalid && req_tready) ? 8'd2 : 8'd0)
                    - ((rsp_tvalid && rsp_tready) ? 8'd1 : 8'd0);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_last_alt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == exp_last_ff)
      else $error("tlast does not alternate first/second sample");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> owed_ff != 8'd0)
      else $error("response without an owed request");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind pdm_cic_fir_decimator_top pcfd_checker u_pcfd_checker (.*);

`default_nettype wire
